// ===== sv/bbc_pkg.sv =====
`default_nettype none
package bbc_pkg;

  // Field widths fixed by the beat format
  localparam int SYM_W   = 8;
  localparam int POS_W   = 8;
  localparam int DEPTH_W = 6;
  localparam int KIND_W  = 2;

  // Bracket characters
  localparam logic [SYM_W-1:0] CH_OPEN_PAREN  = 8'h28;  // (
  localparam logic [SYM_W-1:0] CH_OPEN_SQUARE = 8'h5B;  // [
  localparam logic [SYM_W-1:0] CH_OPEN_CURLY  = 8'h7B;  // {
  localparam logic [SYM_W-1:0] CH_OPEN_ANGLE  = 8'h3C;  // <
  localparam logic [SYM_W-1:0] CH_CLOSE_PAREN  = 8'h29; // )
  localparam logic [SYM_W-1:0] CH_CLOSE_SQUARE = 8'h5D; // ]
  localparam logic [SYM_W-1:0] CH_CLOSE_CURLY  = 8'h7D; // }
  localparam logic [SYM_W-1:0] CH_CLOSE_ANGLE  = 8'h3E; // >

  // Bracket kind codes held in the stack cells
  localparam logic [KIND_W-1:0] KIND_PAREN  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SQUARE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CURLY  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_ANGLE  = 2'd3;

  // Line status codes
  localparam logic [1:0] ST_BALANCED   = 2'd0;
  localparam logic [1:0] ST_INCOMPLETE = 2'd1;
  localparam logic [1:0] ST_CORRUPTED  = 2'd2;
  localparam logic [1:0] ST_OVERFLOW   = 2'd3;

  // Record kinds
  localparam logic REC_SUMMARY = 1'b0;
  localparam logic REC_CLOSER  = 1'b1;

  // Shift command for the cell chain
  typedef struct packed {
    logic push;  // every cell takes its upper neighbor
    logic pop;   // every cell takes its lower neighbor
  } bbc_shift_t;

  // Classify an opener: {hit, kind}
  function automatic logic [KIND_W:0] open_kind(input logic [SYM_W-1:0] c);
    logic [KIND_W:0] r;
    case (c)
      CH_OPEN_PAREN:  r = {1'b1, KIND_PAREN};
      CH_OPEN_SQUARE: r = {1'b1, KIND_SQUARE};
      CH_OPEN_CURLY:  r = {1'b1, KIND_CURLY};
      CH_OPEN_ANGLE:  r = {1'b1, KIND_ANGLE};
      default:        r = '0;
    endcase
    return r;
  endfunction

  // Classify a closer: {hit, kind}
  function automatic logic [KIND_W:0] close_kind(input logic [SYM_W-1:0] c);
    logic [KIND_W:0] r;
    case (c)
      CH_CLOSE_PAREN:  r = {1'b1, KIND_PAREN};
      CH_CLOSE_SQUARE: r = {1'b1, KIND_SQUARE};
      CH_CLOSE_CURLY:  r = {1'b1, KIND_CURLY};
      CH_CLOSE_ANGLE:  r = {1'b1, KIND_ANGLE};
      default:         r = '0;
    endcase
    return r;
  endfunction

  // Closing character for a kind code
  function automatic logic [SYM_W-1:0] closer_of(input logic [KIND_W-1:0] k);
    logic [SYM_W-1:0] r;
    case (k)
      KIND_PAREN:  r = CH_CLOSE_PAREN;
      KIND_SQUARE: r = CH_CLOSE_SQUARE;
      KIND_CURLY:  r = CH_CLOSE_CURLY;
      default:     r = CH_CLOSE_ANGLE;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/bbc_in_if.sv =====
`default_nettype none
interface bbc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       end_of_line;

  modport source (output valid, output symbol, output end_of_line, input ready);
  modport sink   (input valid, input symbol, input end_of_line, output ready);
endinterface
`default_nettype wire

// ===== sv/bbc_out_if.sv =====
`default_nettype none
interface bbc_out_if;
  logic       valid;
  logic       ready;
  logic       record_kind;
  logic [1:0] status;
  logic [7:0] error_position;
  logic [7:0] bad_symbol;
  logic [5:0] open_depth;
  logic [7:0] closer;
  logic       last;

  modport source (output valid, output record_kind, output status,
                  output error_position, output bad_symbol, output open_depth,
                  output closer, output last, input ready);
  modport sink   (input valid, input record_kind, input status,
                  input error_position, input bad_symbol, input open_depth,
                  input closer, input last, output ready);
endinterface
`default_nettype wire

// ===== sv/bbc_cell.sv =====
`default_nettype none
// One stack entry; shifts toward the bottom on push, toward the top on pop.
module bbc_cell (
  input  wire logic                        clk,
  input  wire bbc_pkg::bbc_shift_t         shift,
  input  wire logic [bbc_pkg::KIND_W-1:0]  from_above,
  input  wire logic [bbc_pkg::KIND_W-1:0]  from_below,
  output logic      [bbc_pkg::KIND_W-1:0]  value
);
  import bbc_pkg::*;

  // Payload only, no reset
  always_ff @(posedge clk) begin
    if (shift.push) begin
      value <= from_above;
    end else if (shift.pop) begin
      value <= from_below;
    end
  end

endmodule
`default_nettype wire

// ===== sv/bracket_balance_checker.sv =====
`default_nettype none
// Bracket balance checker. Takes one line character per beat and tracks open
// brackets ( [ { < in a chain of STACK_DEPTH shift cells, top of stack in the
// first cell. A character is taken every cycle while the result register is
// free; the end of a line loads one summary beat. After an incomplete line
// the input stalls while the chain shifts up and the missing closers leave,
// innermost first, one per cycle from the top cell while the result register
// is free. Corrupted and overflowed lines give the summary only. Positions
// saturate at the lesser of LINE_LENGTH-1 and 255. No clearing pass is
// needed after reset.
module bracket_balance_checker #(
  parameter int STACK_DEPTH = 32,
  parameter int LINE_LENGTH = 256
) (
  input  wire logic clk,
  input  wire logic rst,
  bbc_in_if.sink    chars,
  bbc_out_if.source results
);
  import bbc_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int POS_LIMIT_INT = (LINE_LENGTH - 1 < 255) ? LINE_LENGTH - 1 : 255;
  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(POS_LIMIT_INT);
  localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

  typedef enum logic {S_RUN, S_DRAIN} state_t;

  state_t               state, state_next;
  logic [CW-1:0]        count, count_next;
  logic [POS_W-1:0]     position, position_next;
  logic                 corrupted, corrupted_next;
  logic                 overflow, overflow_next;
  logic [POS_W-1:0]     err_pos, err_pos_next;
  logic [SYM_W-1:0]     err_sym, err_sym_next;
  logic [DEPTH_W-1:0]   drain_depth, drain_depth_next;

  logic                 out_valid, out_valid_next;
  logic                 out_kind, out_kind_next;
  logic [1:0]           out_status, out_status_next;
  logic [POS_W-1:0]     out_pos, out_pos_next;
  logic [SYM_W-1:0]     out_sym, out_sym_next;
  logic [DEPTH_W-1:0]   out_depth, out_depth_next;
  logic [SYM_W-1:0]     out_closer, out_closer_next;
  logic                 out_last, out_last_next;

  logic [KIND_W-1:0]    cells [STACK_DEPTH];
  logic [KIND_W-1:0]    top;
  logic [KIND_W:0]      oc, cc;
  logic                 slot_free, accept, active, full, match, drain_go;
  logic                 push_run, pop_run, ovf_set, bad_set;
  logic [CW+DEPTH_W-1:0] count_ext;
  bbc_shift_t           shift;

  assign top       = cells[0];
  assign slot_free = !out_valid || results.ready;
  assign chars.ready = (state == S_RUN) && slot_free;
  assign accept    = chars.valid && chars.ready;
  assign oc        = open_kind(chars.symbol);
  assign cc        = close_kind(chars.symbol);
  assign active    = !corrupted && !overflow;
  assign full      = (count == FULL);
  assign match     = (count != '0) && (top == cc[KIND_W-1:0]);
  assign push_run  = accept && active && oc[KIND_W] && !full;
  assign ovf_set   = accept && active && oc[KIND_W] && full;
  assign pop_run   = accept && active && cc[KIND_W] && match;
  assign bad_set   = accept && active && cc[KIND_W] && !match;
  assign drain_go  = (state == S_DRAIN) && slot_free;

  assign shift.push = push_run;
  assign shift.pop  = pop_run || drain_go;

  // Cell chain: cell 0 is the top of stack
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [KIND_W-1:0] above, below;
    if (i == 0) begin : g_top
      assign above = oc[KIND_W-1:0];
    end else begin : g_mid
      assign above = cells[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bot
      assign below = cells[i];
    end else begin : g_low
      assign below = cells[i+1];
    end
    bbc_cell u_cell (
      .clk        (clk),
      .shift      (shift),
      .from_above (above),
      .from_below (below),
      .value      (cells[i])
    );
  end

  // Next state of the line trackers and the result register
  always_comb begin
    logic [CW-1:0] cnt_c;
    logic          cor_c;
    logic          ovf_c;
    logic [POS_W-1:0] pos_c;
    logic [SYM_W-1:0] sym_c;

    state_next       = state;
    count_next       = count;
    position_next    = position;
    corrupted_next   = corrupted;
    overflow_next    = overflow;
    err_pos_next     = err_pos;
    err_sym_next     = err_sym;
    drain_depth_next = drain_depth;
    out_valid_next   = out_valid && !results.ready;
    out_kind_next    = out_kind;
    out_status_next  = out_status;
    out_pos_next     = out_pos;
    out_sym_next     = out_sym;
    out_depth_next   = out_depth;
    out_closer_next  = out_closer;
    out_last_next    = out_last;

    cnt_c = count;
    if (push_run) cnt_c = count + 1'b1;
    if (pop_run)  cnt_c = count - 1'b1;
    cor_c = corrupted || bad_set;
    ovf_c = overflow || ovf_set;
    pos_c = bad_set ? position : err_pos;
    sym_c = bad_set ? chars.symbol : err_sym;
    count_ext = {{DEPTH_W{1'b0}}, cnt_c};

    if (accept) begin
      count_next     = cnt_c;
      corrupted_next = cor_c;
      overflow_next  = ovf_c;
      err_pos_next   = pos_c;
      err_sym_next   = sym_c;
      position_next  = (position < POS_LIMIT) ? position + 1'b1 : position;
      if (chars.end_of_line) begin
        out_valid_next  = 1'b1;
        out_kind_next   = REC_SUMMARY;
        out_pos_next    = '0;
        out_sym_next    = '0;
        out_depth_next  = count_ext[DEPTH_W-1:0];
        out_closer_next = '0;
        out_last_next   = 1'b1;
        if (cor_c) begin
          out_status_next = ST_CORRUPTED;
          out_pos_next    = pos_c;
          out_sym_next    = sym_c;
        end else if (ovf_c) begin
          out_status_next = ST_OVERFLOW;
        end else if (cnt_c == '0) begin
          out_status_next = ST_BALANCED;
        end else begin
          out_status_next  = ST_INCOMPLETE;
          out_last_next    = 1'b0;
          drain_depth_next = count_ext[DEPTH_W-1:0];
          state_next       = S_DRAIN;
        end
        // line state clears; the count stays for the drain when incomplete
        if (cor_c || ovf_c || cnt_c == '0) count_next = '0;
        position_next  = '0;
        corrupted_next = 1'b0;
        overflow_next  = 1'b0;
        err_pos_next   = '0;
        err_sym_next   = '0;
      end
    end

    // Drain: one closer per cycle from the top cell while the result register is free
    if (drain_go) begin
      out_valid_next  = 1'b1;
      out_kind_next   = REC_CLOSER;
      out_status_next = ST_INCOMPLETE;
      out_pos_next    = '0;
      out_sym_next    = '0;
      out_depth_next  = drain_depth;
      out_closer_next = closer_of(top);
      out_last_next   = (count == CW'(1));
      count_next      = count - 1'b1;
      if (count == CW'(1)) state_next = S_RUN;
    end
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_RUN;
      count     <= '0;
      position  <= '0;
      corrupted <= 1'b0;
      overflow  <= 1'b0;
      err_pos   <= '0;
      err_sym   <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      position  <= position_next;
      corrupted <= corrupted_next;
      overflow  <= overflow_next;
      err_pos   <= err_pos_next;
      err_sym   <= err_sym_next;
      out_valid <= out_valid_next;
    end
    drain_depth <= drain_depth_next;
    out_kind    <= out_kind_next;
    out_status  <= out_status_next;
    out_pos     <= out_pos_next;
    out_sym     <= out_sym_next;
    out_depth   <= out_depth_next;
    out_closer  <= out_closer_next;
    out_last    <= out_last_next;
  end

  assign results.valid          = out_valid;
  assign results.record_kind    = out_kind;
  assign results.status         = out_status;
  assign results.error_position = out_pos;
  assign results.bad_symbol     = out_sym;
  assign results.open_depth     = out_depth;
  assign results.closer         = out_closer;
  assign results.last           = out_last;

`ifndef SYNTHESIS
  // stack never holds more than its depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL) else $error("stack count above depth");

  // draining only with something left in the chain
  a_drain_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == S_DRAIN |-> count != '0) else $error("drain with empty stack");

  // a line is never both corrupted and overflowed
  a_one_fault: assert property (@(posedge clk) disable iff (rst)
    !(corrupted && overflow)) else $error("two faults on one line");

  // a pushed opener lands in the top cell
  a_push_top: assert property (@(posedge clk) disable iff (rst)
    push_run |=> top == $past(oc[KIND_W-1:0])) else $error("push lost");

  // the final closer ends the drain and is marked last
  a_drain_end: assert property (@(posedge clk) disable iff (rst)
    drain_go && count == CW'(1) |=> state == S_RUN && out_valid && out_last)
    else $error("drain did not end on last closer");
`endif

endmodule
`default_nettype wire

// ===== tb/bbc_record_checker.sv =====
module bbc_record_checker #(
  parameter int STACK_DEPTH = 32,
  parameter int LINE_LENGTH = 256
) (
  input  wire logic clk,
  input  wire logic rst,
  bbc_in_if         chars,
  bbc_out_if        results,
  output int        mismatches,
  output int        outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import bbc_pkg::*;

  localparam int POS_LIMIT = (LINE_LENGTH - 1 < 255) ? LINE_LENGTH - 1 : 255;
  localparam int PRINT_CAP = 100;

  // Index order follows the kind codes
  localparam logic [SYM_W-1:0] OPENERS [4] = '{CH_OPEN_PAREN, CH_OPEN_SQUARE,
                                               CH_OPEN_CURLY, CH_OPEN_ANGLE};
  localparam logic [SYM_W-1:0] CLOSERS [4] = '{CH_CLOSE_PAREN, CH_CLOSE_SQUARE,
                                               CH_CLOSE_CURLY, CH_CLOSE_ANGLE};

  typedef struct packed {
    logic               record_kind;
    logic [1:0]         status;
    logic [POS_W-1:0]   error_position;
    logic [SYM_W-1:0]   bad_symbol;
    logic [DEPTH_W-1:0] open_depth;
    logic [SYM_W-1:0]   closer;
    logic               last;
  } line_record_t;

  line_record_t due_records[$];

  // Line state as the block should hold it
  logic [KIND_W-1:0] open_kinds [STACK_DEPTH];
  int unsigned       depth_now;
  int unsigned       pos_now;
  bit                corrupt_seen;
  bit                overflow_seen;
  logic [POS_W-1:0]  fault_pos;
  logic [SYM_W-1:0]  fault_sym;

  int fail_tally = 0;
  int beat_no = 0;

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic int bracket_index(input logic [SYM_W-1:0] c, input bit closing);
    for (int k = 0; k < 4; k++)
      if (c == (closing ? CLOSERS[k] : OPENERS[k])) return k;
    return -1;
  endfunction

  task automatic clear_line();
    depth_now     = 0;
    pos_now       = 0;
    corrupt_seen  = 0;
    overflow_seen = 0;
    fault_pos     = '0;
    fault_sym     = '0;
  endtask

  task automatic report_mismatch(input string field, input int got, input int want);
    fail_tally++;
    if (fail_tally <= PRINT_CAP)
      $display("%0t: result beat %0d, %s: got %0d, expected %0d",
               $time, beat_no, field, got, want);
  endtask

  // Advance the line state by one character; queue the records of a line end
  task automatic judge_char(input logic [SYM_W-1:0] sym, input logic eol);
    int           ko;
    int           kc;
    line_record_t rec;
    ko = bracket_index(sym, 1'b0);
    kc = bracket_index(sym, 1'b1);
    // once the line is faulted, nothing more is examined
    if (!corrupt_seen && !overflow_seen) begin
      if (ko >= 0) begin
        if (depth_now >= STACK_DEPTH) begin
          overflow_seen = 1;
        end else begin
          open_kinds[depth_now] = KIND_W'(ko);
          depth_now++;
        end
      end else if (kc >= 0) begin
        if (depth_now > 0 && open_kinds[depth_now-1] == KIND_W'(kc)) begin
          depth_now--;
        end else begin
          corrupt_seen = 1;
          fault_pos    = POS_W'(pos_now);
          fault_sym    = sym;
        end
      end
    end
    if (pos_now < POS_LIMIT) pos_now++;

    if (eol) begin
      rec             = '0;
      rec.record_kind = REC_SUMMARY;
      rec.open_depth  = DEPTH_W'(depth_now);
      rec.last        = 1'b1;
      if (corrupt_seen) begin
        rec.status         = ST_CORRUPTED;
        rec.error_position = fault_pos;
        rec.bad_symbol     = fault_sym;
        due_records.push_back(rec);
      end else if (overflow_seen) begin
        rec.status = ST_OVERFLOW;
        due_records.push_back(rec);
      end else if (depth_now == 0) begin
        rec.status = ST_BALANCED;
        due_records.push_back(rec);
      end else begin
        // summary, then missing closers innermost first
        rec.status = ST_INCOMPLETE;
        rec.last   = 1'b0;
        due_records.push_back(rec);
        rec.record_kind = REC_CLOSER;
        for (int unsigned i = depth_now; i > 0; i--) begin
          rec.closer = CLOSERS[open_kinds[i-1]];
          rec.last   = (i == 1);
          due_records.push_back(rec);
        end
      end
      clear_line();
    end
  endtask

  task automatic check_record(input line_record_t got);
    line_record_t want;
    beat_no++;
    if (due_records.size() == 0) begin
      report_mismatch("beat with no record due, status", got.status, -1);
      return;
    end
    want = due_records.pop_front();
    if (got.record_kind != want.record_kind)
      report_mismatch("record_kind", got.record_kind, want.record_kind);
    if (got.status != want.status)
      report_mismatch("status", got.status, want.status);
    if (got.error_position != want.error_position)
      report_mismatch("error_position", got.error_position, want.error_position);
    if (got.bad_symbol != want.bad_symbol)
      report_mismatch("bad_symbol", got.bad_symbol, want.bad_symbol);
    if (got.open_depth != want.open_depth)
      report_mismatch("open_depth", got.open_depth, want.open_depth);
    if (got.closer != want.closer)
      report_mismatch("closer", got.closer, want.closer);
    if (got.last != want.last)
      report_mismatch("last", got.last, want.last);
  endtask

  // Watch both channels at each edge
  always @(posedge clk) begin
    if (rst) begin
      clear_line();
      due_records.delete();
    end else begin
      if (chars.valid && chars.ready)
        judge_char(chars.symbol, chars.end_of_line);
      if (results.valid && results.ready)
        check_record({results.record_kind, results.status, results.error_position,
                      results.bad_symbol, results.open_depth, results.closer,
                      results.last});
    end
    outstanding <= due_records.size();
    mismatches  <= fail_tally;
  end

endmodule

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bbc_pkg::*;

  localparam int STACK_DEPTH   = 32;
  localparam int LINE_LENGTH   = 256;
  localparam int RANDOM_ITEMS  = 160;
  localparam int HOLD_CYCLES   = 150;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 200000;

  // Shapes of generated lines
  localparam int SHAPE_BALANCED   = 0;
  localparam int SHAPE_INCOMPLETE = 1;
  localparam int SHAPE_CORRUPTED  = 2;
  localparam int SHAPE_NOISE      = 3;
  localparam int SHAPE_OVERFLOW   = 4;
  localparam int SHAPE_FULL       = 5;
  localparam int SHAPE_LONG       = 6;

  localparam logic [SYM_W-1:0] OPENERS [4] = '{CH_OPEN_PAREN, CH_OPEN_SQUARE,
                                               CH_OPEN_CURLY, CH_OPEN_ANGLE};
  localparam logic [SYM_W-1:0] CLOSERS [4] = '{CH_CLOSE_PAREN, CH_CLOSE_SQUARE,
                                               CH_CLOSE_CURLY, CH_CLOSE_ANGLE};

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   mismatches;
  int   outstanding;

  bit   tx_steady = 1'b0;
  bit   rx_steady = 1'b0;
  bit   hold_off_req = 1'b0;
  int   random_sent = 0;

  logic [SYM_W-1:0] line_buf[$];

  bbc_in_if  chars();
  bbc_out_if results();

  bracket_balance_checker #(
    .STACK_DEPTH(STACK_DEPTH),
    .LINE_LENGTH(LINE_LENGTH)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars),
    .results (results)
  );

  bbc_record_checker #(
    .STACK_DEPTH(STACK_DEPTH),
    .LINE_LENGTH(LINE_LENGTH)
  ) i_checker (
    .clk         (clk),
    .rst         (rst),
    .chars       (chars),
    .results     (results),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [SYM_W-1:0] filler();
    // letters or high bytes, never a bracket
    if ($urandom_range(0, 1))
      return SYM_W'($urandom_range(8'h61, 8'h7A));
    return SYM_W'($urandom_range(8'h80, 8'hFF));
  endfunction

  function automatic logic [SYM_W-1:0] any_bracket();
    if ($urandom_range(0, 1))
      return CLOSERS[$urandom_range(0, 3)];
    return OPENERS[$urandom_range(0, 3)];
  endfunction

  // Fill line_buf with one line of the given shape
  task automatic compose_line(input int shape);
    int open_stack[$];
    int cap;
    int steps;
    int kind;
    line_buf.delete();
    case (shape)
      SHAPE_NOISE: begin
        repeat ($urandom_range(1, 8)) line_buf.push_back(SYM_W'($urandom_range(0, 255)));
      end
      SHAPE_OVERFLOW: begin
        repeat (STACK_DEPTH + $urandom_range(1, 3))
          line_buf.push_back(OPENERS[$urandom_range(0, 3)]);
        repeat ($urandom_range(0, 4)) line_buf.push_back(any_bracket());
      end
      SHAPE_FULL: begin
        repeat (STACK_DEPTH) line_buf.push_back(OPENERS[$urandom_range(0, 3)]);
      end
      SHAPE_LONG: begin
        // bad closer well past the saturation point of the position
        line_buf.push_back(CH_OPEN_PAREN);
        repeat (258) line_buf.push_back(filler());
        line_buf.push_back(CH_CLOSE_SQUARE);
        repeat (3) line_buf.push_back(filler());
      end
      default: begin
        // nested brackets with filler, then ended per shape
        cap   = ($urandom_range(0, 7) == 0) ? STACK_DEPTH : $urandom_range(1, 8);
        steps = $urandom_range(1, 16);
        repeat (steps) begin
          if ($urandom_range(0, 4) == 0) begin
            line_buf.push_back(filler());
          end else if (open_stack.size() < cap &&
                       (open_stack.size() == 0 || $urandom_range(0, 1))) begin
            kind = $urandom_range(0, 3);
            open_stack.push_back(kind);
            line_buf.push_back(OPENERS[kind]);
          end else begin
            line_buf.push_back(CLOSERS[open_stack.pop_back()]);
          end
        end
        if (shape == SHAPE_BALANCED) begin
          while (open_stack.size() > 0) line_buf.push_back(CLOSERS[open_stack.pop_back()]);
        end else if (shape == SHAPE_INCOMPLETE) begin
          if (open_stack.size() == 0) line_buf.push_back(OPENERS[$urandom_range(0, 3)]);
        end else begin
          if (open_stack.size() == 0)
            line_buf.push_back(CLOSERS[$urandom_range(0, 3)]);
          else
            line_buf.push_back(CLOSERS[(open_stack[$] + $urandom_range(1, 3)) % 4]);
          repeat ($urandom_range(0, 5)) line_buf.push_back(SYM_W'($urandom_range(0, 255)));
        end
      end
    endcase
  endtask

  task automatic send_char(input logic [SYM_W-1:0] sym, input logic eol);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      chars.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    chars.symbol      <= sym;
    chars.end_of_line <= eol;
    chars.valid       <= 1'b1;
    do @(posedge clk); while (!chars.ready);
  endtask

  task automatic send_line();
    foreach (line_buf[i]) send_char(line_buf[i], i == line_buf.size() - 1);
  endtask

  // Stop offering and wait until every expected record has come
  task automatic await_all_records();
    chars.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Result receiver with random stalls, one long hold-off on request
  initial begin
    int stall;
    int beats;
    results.ready <= 1'b0;
    while (rst) @(posedge clk);
    beats = 0;
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        results.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (beats % 24 == 0) rx_steady = ($urandom_range(0, 2) == 0);
      stall = rx_steady ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        results.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      results.ready <= 1'b1;
      do @(posedge clk); while (!results.valid);
      beats++;
    end
  end

  // Character source and verdict
  initial begin
    int line_no;
    int shape;
    chars.valid       <= 1'b0;
    chars.symbol      <= '0;
    chars.end_of_line <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // every bracket, opened and closed in order
    line_buf = '{CH_OPEN_PAREN, CH_OPEN_SQUARE, CH_OPEN_CURLY, CH_OPEN_ANGLE,
                 CH_CLOSE_ANGLE, CH_CLOSE_CURLY, CH_CLOSE_SQUARE, CH_CLOSE_PAREN};
    send_line();
    // closer on an empty stack at the first character
    line_buf = '{CH_CLOSE_PAREN};
    send_line();
    // mismatched closer; the rest of the line is ignored
    line_buf = '{CH_OPEN_PAREN, CH_CLOSE_SQUARE, CH_OPEN_PAREN, 8'h00};
    send_line();
    // incomplete line ending on an all-ones byte
    line_buf = '{CH_OPEN_SQUARE, CH_OPEN_ANGLE, 8'hFF};
    send_line();
    // line of one non-bracket byte
    line_buf = '{8'h00};
    send_line();

    // random lines, with the special lines at fixed places
    line_no = 0;
    while (random_sent < RANDOM_ITEMS) begin
      tx_steady = ($urandom_range(0, 3) == 0);
      if (line_no == 1) hold_off_req = 1'b1;
      if (line_no == 10) await_all_records();
      case (line_no)
        3:       shape = SHAPE_FULL;
        8, 20:   shape = SHAPE_OVERFLOW;
        12:      shape = SHAPE_LONG;
        default: begin
          case ($urandom_range(0, 9))
            0, 1, 2: shape = SHAPE_BALANCED;
            3, 4, 5: shape = SHAPE_INCOMPLETE;
            6, 7:    shape = SHAPE_CORRUPTED;
            default: shape = SHAPE_NOISE;
          endcase
        end
      endcase
      compose_line(shape);
      send_line();
      if (shape != SHAPE_LONG) random_sent += line_buf.size();
      line_no++;
    end

    await_all_records();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
